@@ rtl/core/ace_pkg.sv @@
// ----------------------------------------------------------------------------
// ace_pkg
// Types, codes and constants shared by the address claim engine modules.
// ----------------------------------------------------------------------------
package ace_pkg;

  localparam int MAP_DEPTH      = 256;
  localparam int MAP_AW         = $clog2(MAP_DEPTH);
  localparam int DYN_START      = 128;
  localparam int TIMER_BITS_DEF = 10;

  localparam logic [7:0]  NO_ADDR       = 8'hFE;
  localparam logic [7:0]  GLOBAL_ADDR   = 8'hFF;
  localparam logic [17:0] PGN_REQUEST   = 18'h0EA00;
  localparam logic [17:0] PGN_COMMANDED = 18'h0FED8;
  localparam logic [23:0] PGN_CLAIM     = 24'h00EE00;
  localparam logic [3:0]  COMMANDED_LEN = 4'd9;

  typedef enum logic [1:0] {OP_TICK, OP_FRAME, OP_VIOL, OP_OCC} opcode_t;

  typedef enum logic [1:0] {TX_NONE, TX_REQUEST, TX_CLAIM, TX_CANNOT} tx_kind_t;

  typedef enum logic [3:0] {
    PH_NONE, PH_WAIT, PH_SEND_REQ, PH_CONTENTION, PH_PREFERRED, PH_CONTEND,
    PH_ARBITRARY, PH_RECLAIM, PH_UNABLE, PH_COMPLETE
  } phase_t;

  typedef enum logic [1:0] {
    REG_OWN_NAME, REG_PREF_INIT, REG_CLAIM_DELAY, REG_CONTENTION
  } reg_idx_t;

  typedef enum logic [2:0] {
    CS_CLEAR, CS_IDLE, CS_LOOK, CS_TAKE, CS_SCAN, CS_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic clear_wr;
    logic take;
    logic look;
    logic capture;
    logic scan_start;
    logic scan;
    logic commit;
  } ace_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic need_scan;
    logic scan_hit;
    logic out_free;
  } ace_status_t;

  // last address of the dynamic range per industry group
  function automatic logic [7:0] range_end(input logic [2:0] grp);
    logic [7:0] r;
    case (grp)
      3'd0: r = 8'd247;
      3'd1: r = 8'd158;
      3'd2: r = 8'd235;
      3'd3, 3'd4, 3'd5: r = 8'd207;
      default: r = 8'(DYN_START);
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/ace_in_if.sv @@
// ----------------------------------------------------------------------------
// ace_in_if
// Input item channel of the address claim engine.
// ----------------------------------------------------------------------------
interface ace_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [17:0] frame_pgn;
  logic [23:0] requested_pgn;
  logic [7:0]  dest_address;
  logic [7:0]  source_address;
  logic [3:0]  data_length;
  logic        to_known_node;
  logic [63:0] target_name;
  logic [7:0]  addr_value;
  logic        occupied;
  logic [63:0] occupant_name;
  logic        tx_ok;

  modport source (
    output valid, opcode, frame_pgn, requested_pgn, dest_address, source_address,
           data_length, to_known_node, target_name, addr_value, occupied,
           occupant_name, tx_ok,
    input  ready
  );
  modport sink (
    input  valid, opcode, frame_pgn, requested_pgn, dest_address, source_address,
           data_length, to_known_node, target_name, addr_value, occupied,
           occupant_name, tx_ok,
    output ready
  );
endinterface

@@ rtl/core/ace_out_if.sv @@
// ----------------------------------------------------------------------------
// ace_out_if
// Result channel of the address claim engine.
// ----------------------------------------------------------------------------
interface ace_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] tx_kind;
  logic [7:0] tx_address;
  logic       claimed;
  logic       violation;
  logic [3:0] claim_state;
  logic [7:0] own_address;

  modport source (
    output valid, tx_kind, tx_address, claimed, violation, claim_state, own_address,
    input  ready
  );
  modport sink (
    input  valid, tx_kind, tx_address, claimed, violation, claim_state, own_address,
    output ready
  );
endinterface

@@ rtl/core/ace_ram.sv @@
// ----------------------------------------------------------------------------
// ace_ram
// Generic simple dual port RAM with registered read.
// ----------------------------------------------------------------------------
module ace_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/ace_ctrl.sv @@
// ----------------------------------------------------------------------------
// ace_ctrl
// Sequencer: map clearing, item intake, map lookup, free address scan, commit.
// ----------------------------------------------------------------------------
module ace_ctrl
  import ace_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ace_status_t status,
  output ace_cmd_t    cmd
);
  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      CS_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_done) state_next = CS_IDLE;
      end
      CS_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid) state_next = CS_LOOK;
      end
      CS_LOOK: begin
        cmd.look   = 1'b1;
        state_next = CS_TAKE;
      end
      CS_TAKE: begin
        cmd.capture = 1'b1;
        if (status.need_scan) begin
          cmd.scan_start = 1'b1;
          state_next     = CS_SCAN;
        end else begin
          state_next = CS_EXEC;
        end
      end
      CS_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_hit) state_next = CS_EXEC;
      end
      CS_EXEC: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_CLEAR;
    endcase
  end
endmodule

@@ rtl/core/ace_dp.sv @@
// ----------------------------------------------------------------------------
// ace_dp
// Datapath: item latch, claim state, occupancy map, scan unit, result register.
// ----------------------------------------------------------------------------
module ace_dp
  import ace_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ace_in_if.sink      item_in,
  ace_out_if.source   result_out,
  input  ace_cmd_t    cmd,
  output ace_status_t status,
  input  logic [63:0] own_name,
  input  logic [7:0]  claim_delay_ms,
  input  logic [9:0]  contention_ms,
  input  logic        pref_load,
  input  logic [7:0]  pref_value
);
  localparam int CW = (TIMER_BITS > 10) ? TIMER_BITS : 10;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  // latched item
  opcode_t     opcode;
  logic [17:0] frame_pgn;
  logic [23:0] requested_pgn;
  logic [7:0]  dest_address, source_address, addr_value;
  logic [3:0]  data_length;
  logic        to_known_node, occupied, tx_ok;
  logic [63:0] target_name, occupant_name;

  // claim state
  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] elapsed, elapsed_next, el_inc;
  logic [7:0]            held, held_next, pref, pref_next;

  // map and scan
  logic              ram_we, ram_rd;
  logic [MAP_AW-1:0] ram_waddr, ram_raddr, clr_cnt;
  logic              ram_wdata;
  logic              taken;
  logic [7:0]        scan_addr, chk_addr, found_addr, end_addr;
  logic              chk_vld, found;

  // result
  tx_kind_t   tx_kind;
  logic [7:0] tx_address;
  logic       claimed, violation, enter;
  logic       out_valid;

  assign end_addr = range_end(own_name[62:60]);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      opcode         <= opcode_t'(item_in.opcode);
      frame_pgn      <= item_in.frame_pgn;
      requested_pgn  <= item_in.requested_pgn;
      dest_address   <= item_in.dest_address;
      source_address <= item_in.source_address;
      data_length    <= item_in.data_length;
      to_known_node  <= item_in.to_known_node;
      target_name    <= item_in.target_name;
      addr_value     <= item_in.addr_value;
      occupied       <= item_in.occupied;
      occupant_name  <= item_in.occupant_name;
      tx_ok          <= item_in.tx_ok;
    end
  end

  // map port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = 1'b0;
    if (cmd.clear_wr) begin
      ram_we = 1'b1;
    end else if (cmd.commit && opcode == OP_OCC) begin
      ram_we    = 1'b1;
      ram_waddr = MAP_AW'(addr_value);
      ram_wdata = occupied;
    end
    if (cmd.scan) begin
      ram_raddr = MAP_AW'(scan_addr);
    end else if (opcode == OP_FRAME) begin
      ram_raddr = MAP_AW'(addr_value);
    end else begin
      ram_raddr = MAP_AW'(pref);
    end
  end

  ace_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // scan pipeline: one map entry read per cycle, checked against the registered map read data
  always_ff @(posedge clk) begin
    if (cmd.capture) taken <= ram_rd;
    if (cmd.scan_start) begin
      scan_addr <= 8'(DYN_START);
      chk_vld   <= 1'b0;
    end else if (cmd.scan) begin
      scan_addr <= scan_addr + 8'd1;
      chk_addr  <= scan_addr;
      chk_vld   <= 1'b1;
      if (status.scan_hit) begin
        found      <= !ram_rd;
        found_addr <= chk_addr;
      end
    end
  end

  assign status.clear_done = (clr_cnt == '1);
  assign status.need_scan  = (opcode == OP_TICK) && (phase == PH_ARBITRARY);
  assign status.scan_hit   = chk_vld && (!ram_rd || chk_addr == end_addr);
  assign status.out_free   = !out_valid || result_out.ready;

  assign el_inc = (elapsed == TIMER_MAX) ? elapsed : elapsed + 1'b1;

  function automatic logic expired(input logic [TIMER_BITS-1:0] el,
                                   input logic [9:0] dly);
    return (CW'(el) >= CW'(dly)) || (el == TIMER_MAX);
  endfunction

  // item execution
  always_comb begin
    phase_next = phase;
    held_next  = held;
    pref_next  = pref;
    tx_kind    = TX_NONE;
    tx_address = 8'd0;
    claimed    = 1'b0;
    violation  = 1'b0;
    enter      = 1'b0;
    elapsed_next = elapsed;
    case (opcode)
      OP_TICK: begin
        elapsed_next = el_inc;
        case (phase)
          PH_NONE: begin
            phase_next = PH_WAIT; enter = 1'b1;
          end
          PH_WAIT: begin
            if (expired(el_inc, {2'b00, claim_delay_ms})) begin
              phase_next = PH_SEND_REQ; enter = 1'b1;
            end
          end
          PH_SEND_REQ: begin
            tx_kind = TX_REQUEST; tx_address = NO_ADDR;
            if (tx_ok) begin
              phase_next = PH_CONTENTION; enter = 1'b1;
            end
          end
          PH_CONTENTION: begin
            if (expired(el_inc, contention_ms)) begin
              enter = 1'b1;
              if (pref != NO_ADDR && !taken) begin
                phase_next = PH_PREFERRED;
              end else if (own_name[63]) begin
                phase_next = PH_ARBITRARY;
              end else if (pref != NO_ADDR && taken && occupant_name > own_name) begin
                phase_next = PH_CONTEND;
              end else begin
                phase_next = PH_UNABLE;
                tx_kind = TX_CANNOT; tx_address = NO_ADDR;
                if (tx_ok) held_next = NO_ADDR;
              end
            end
          end
          PH_PREFERRED, PH_CONTEND: begin
            tx_kind = TX_CLAIM; tx_address = pref; enter = 1'b1;
            if (tx_ok) begin
              held_next = pref; claimed = 1'b1; phase_next = PH_COMPLETE;
            end else begin
              phase_next = PH_NONE;
            end
          end
          PH_ARBITRARY: begin
            enter = 1'b1;
            if (found && tx_ok) begin
              tx_kind = TX_CLAIM; tx_address = found_addr;
              held_next = found_addr; claimed = 1'b1;
              if (pref == NO_ADDR) pref_next = found_addr;
              phase_next = PH_COMPLETE;
            end else begin
              tx_kind = TX_CANNOT; tx_address = NO_ADDR;
              if (tx_ok) held_next = NO_ADDR;
              phase_next = PH_UNABLE;
            end
          end
          PH_RECLAIM: begin
            tx_kind = TX_CLAIM; tx_address = held;
            if (tx_ok) begin
              claimed = 1'b1; phase_next = PH_COMPLETE; enter = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_FRAME: begin
        if (frame_pgn == PGN_REQUEST) begin
          if (requested_pgn == PGN_CLAIM && phase == PH_COMPLETE &&
              (dest_address == GLOBAL_ADDR || (held < NO_ADDR && held == dest_address))) begin
            phase_next = PH_RECLAIM; enter = 1'b1;
          end
        end else if (frame_pgn == PGN_COMMANDED) begin
          if (!to_known_node && data_length == COMMANDED_LEN && target_name == own_name &&
              phase == PH_COMPLETE && own_name[63] && addr_value < NO_ADDR) begin
            pref_next = addr_value;
            if (!taken) begin
              phase_next = PH_PREFERRED; enter = 1'b1;
            end else if (occupant_name < own_name) begin
              phase_next = PH_ARBITRARY; enter = 1'b1;
            end
          end
        end
      end
      OP_VIOL: begin
        if (source_address != GLOBAL_ADDR && source_address != NO_ADDR &&
            source_address == held && phase == PH_COMPLETE) begin
          phase_next = PH_RECLAIM; enter = 1'b1; violation = 1'b1;
        end
      end
      default: ;
    endcase
    if (enter) elapsed_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_NONE;
      elapsed <= '0;
      held    <= NO_ADDR;
      pref    <= NO_ADDR;
    end else if (pref_load) begin
      pref <= pref_value;
    end else if (cmd.commit) begin
      phase   <= phase_next;
      elapsed <= elapsed_next;
      held    <= held_next;
      pref    <= pref_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result_out.tx_kind     <= tx_kind;
      result_out.tx_address  <= tx_address;
      result_out.claimed     <= claimed;
      result_out.violation   <= violation;
      result_out.claim_state <= phase_next;
      result_out.own_address <= held_next;
    end
  end

  assign result_out.valid = out_valid;
endmodule

@@ rtl/core/address_claim_engine_core.sv @@
// ----------------------------------------------------------------------------
// address_claim_engine_core
// Address claim engine for one CAN node, with APB configuration registers.
// ----------------------------------------------------------------------------
// flow: an accepted item passes the look and take states, and a tick in the
//   arbitrary phase then runs the free address scan, one map entry a cycle;
//   the result is loaded in the exec state once the result register is free
// intake: one item at a time, next item taken the cycle after its result
//   is loaded; reset: synchronous, then the occupancy map is cleared in one
//   pass over all 256 entries, during which no item is taken
module address_claim_engine_core
  import ace_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ace_in_if.sink      item_in,
  ace_out_if.source   result_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  ace_cmd_t    cmd;
  ace_status_t status;

  logic [63:0] own_name;
  logic [7:0]  pref_init, claim_delay_ms;
  logic [9:0]  contention_ms;
  logic [7:0]  pref_wval;
  logic        cfg_wr, pref_load;
  reg_idx_t    reg_idx;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign reg_idx   = reg_idx_t'(paddr[4:3]);
  assign pref_wval = (pwdata[7:0] == GLOBAL_ADDR) ? NO_ADDR : pwdata[7:0];
  assign pref_load = cfg_wr && reg_idx == REG_PREF_INIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_name       <= '0;
      pref_init      <= NO_ADDR;
      claim_delay_ms <= '0;
      contention_ms  <= 10'd250;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_OWN_NAME:    own_name       <= pwdata;
        REG_PREF_INIT:   pref_init      <= pref_wval;
        REG_CLAIM_DELAY: claim_delay_ms <= pwdata[7:0];
        REG_CONTENTION:  contention_ms  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OWN_NAME:    prdata = own_name;
      REG_PREF_INIT:   prdata = {56'd0, pref_init};
      REG_CLAIM_DELAY: prdata = {56'd0, claim_delay_ms};
      REG_CONTENTION:  prdata = {54'd0, contention_ms};
      default:         prdata = '0;
    endcase
  end

  ace_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(item_in.valid),
    .in_ready(item_in.ready),
    .status  (status),
    .cmd     (cmd)
  );

  ace_dp #(.TIMER_BITS(TIMER_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .item_in       (item_in),
    .result_out    (result_out),
    .cmd           (cmd),
    .status        (status),
    .own_name      (own_name),
    .claim_delay_ms(claim_delay_ms),
    .contention_ms (contention_ms),
    .pref_load     (pref_load),
    .pref_value    (pref_wval)
  );

  // a claimed beat always carries an address claim frame
  a_claim_kind: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.claimed |-> result_out.tx_kind == TX_CLAIM)
    else $error("claimed without claim frame");

  // one item in flight: no intake right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_in.valid && item_in.ready |=> !item_in.ready)
    else $error("second item taken while busy");

  // the held address never reads as the global address
  a_held_addr: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.own_address != GLOBAL_ADDR)
    else $error("held address is global");

  // a result is only loaded while the result register is free and no map scan runs
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free && !cmd.scan)
    else $error("commit while result pending");
endmodule
